>>> rtl/esrv_pkg.sv
// ----------------------------------------------------------------------------
// esrv_pkg
// Shared types, codes and helpers of the expiring server table.
// ----------------------------------------------------------------------------
package esrv_pkg;

  // Default table depth
  localparam int unsigned ESRV_ENTRIES = 4;

  // Field widths
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned IFACE_W  = 32;
  localparam int unsigned EXP_W    = 31;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned TCOUNT_W = 5;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Result status codes
  localparam logic [STAT_W-1:0] ST_REFRESH = 3'd0;
  localparam logic [STAT_W-1:0] ST_ADD     = 3'd1;
  localparam logic [STAT_W-1:0] ST_REPLACE = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXPIRED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STAT_W-1:0] ST_TRIM    = 3'd5;

  // Classified command handed from front to back
  typedef struct packed {
    logic               trim;
    logic               link_local;
    logic [ADDR_W-1:0]  addr_high;
    logic [ADDR_W-1:0]  addr_low;
    logic [IFACE_W-1:0] iface;
    logic [EXP_W-1:0]   expiry;
    logic [EXP_W-1:0]   now;
  } cmd_t;

  // fe80::/10 test on the upper address half
  function automatic logic is_link_local(input logic [ADDR_W-1:0] hi);
    return hi[ADDR_W-1 -: 10] == 10'h3FA;
  endfunction

endpackage

>>> rtl/esrv_if.sv
// ----------------------------------------------------------------------------
// esrv_if
// Valid/ready channels of the expiring server table: update items in,
// table entries out.
// ----------------------------------------------------------------------------
interface esrv_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [31:0] iface_index;
  logic [30:0] new_expiry;
  logic [30:0] now_seconds;

  modport source (output valid, func, addr_high, addr_low, iface_index, new_expiry,
                  now_seconds, input ready);
  modport sink   (input valid, func, addr_high, addr_low, iface_index, new_expiry,
                  now_seconds, output ready);
endinterface

interface esrv_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [63:0] entry_addr_high;
  logic [63:0] entry_addr_low;
  logic [31:0] entry_iface;
  logic [30:0] entry_expiry;
  logic        entry_link_local;
  logic [2:0]  op_status;
  logic [4:0]  table_count;
  logic        is_last;

  modport source (output valid, entry_valid, entry_addr_high, entry_addr_low, entry_iface,
                  entry_expiry, entry_link_local, op_status, table_count, is_last,
                  input ready);
  modport sink   (input valid, entry_valid, entry_addr_high, entry_addr_low, entry_iface,
                  entry_expiry, entry_link_local, op_status, table_count, is_last,
                  output ready);
endinterface

>>> rtl/esrv_front.sv
// ----------------------------------------------------------------------------
// esrv_front
// Accepts input items, decodes the function and flags link-local addresses,
// and holds the classified command in a register for the queue.
// ----------------------------------------------------------------------------
module esrv_front
  import esrv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  esrv_in_if.sink in_i,
  output logic  cmd_valid_o,
  input  logic  cmd_ready_i,
  output cmd_t  cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  // Stage register frees up whenever the queue takes the command
  assign in_i.ready = !valid_q || cmd_ready_i;
  assign take       = in_i.valid && in_i.ready;

  // Classify the item
  always_comb begin
    cmd_d            = cmd_q;
    cmd_d.trim       = in_i.func;
    cmd_d.link_local = is_link_local(in_i.addr_high);
    cmd_d.addr_high  = in_i.addr_high;
    cmd_d.addr_low   = in_i.addr_low;
    cmd_d.iface      = in_i.iface_index;
    cmd_d.expiry     = in_i.new_expiry;
    cmd_d.now        = in_i.now_seconds;
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

>>> rtl/esrv_queue.sv
// ----------------------------------------------------------------------------
// esrv_queue
// Short command FIFO that decouples the front from the table engine.
// ----------------------------------------------------------------------------
module esrv_queue
  import esrv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign wr_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

>>> rtl/esrv_back.sv
// ----------------------------------------------------------------------------
// esrv_back
// Table engine: matches, removes and re-inserts entries in sorted order,
// trims expired tail entries and emits the table through an output register.
// ----------------------------------------------------------------------------
module esrv_back
  import esrv_pkg::*;
#(
  parameter int unsigned ENTRIES = ESRV_ENTRIES
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  esrv_out_if.source out_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_INSERT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]         state_q, state_d;
  cmd_t               cmd_q;
  logic [ENTRIES-1:0] match_q, match_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   wc_q, wc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [IDX_W-1:0]   emit_q, emit_d;

  // Entry storage
  logic [ADDR_W-1:0]  tab_hi_q  [ENTRIES];
  logic [ADDR_W-1:0]  tab_lo_q  [ENTRIES];
  logic [IFACE_W-1:0] tab_if_q  [ENTRIES];
  logic [EXP_W-1:0]   tab_exp_q [ENTRIES];

  // Output register
  logic                out_valid_q, out_valid_d;
  logic                o_evalid_q;
  logic [ADDR_W-1:0]   o_hi_q;
  logic [ADDR_W-1:0]   o_lo_q;
  logic [IFACE_W-1:0]  o_if_q;
  logic [EXP_W-1:0]    o_exp_q;
  logic                o_ll_q;
  logic [STAT_W-1:0]   o_stat_q;
  logic [CNT_W-1:0]    o_cnt_q;
  logic                o_last_q;

  logic               out_free;
  logic               load_out;
  logic               emit_last;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [CNT_W-1:0]   live_cnt;
  logic [CNT_W-1:0]   ins_pos;

  assign cmd_ready_o = state_q == S_IDLE;
  assign out_free    = !out_valid_q || out_o.ready;
  assign load_out    = (state_q == S_EMIT) && out_free;
  assign emit_last   = (cnt_q == '0) || (CNT_W'(emit_q) + CNT_W'(1) == cnt_q);

  // Parallel address match over the live entries
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      match_d[j] = (CNT_W'(j) < cnt_q) &&
                   (tab_hi_q[j] == cmd_q.addr_high) &&
                   (tab_lo_q[j] == cmd_q.addr_low) &&
                   (!cmd_q.link_local || (tab_if_q[j] == cmd_q.iface));
    end
  end

  // First matching entry
  always_comb begin
    hit     = |match_q;
    hit_idx = '0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (match_q[j]) begin
        hit_idx = IDX_W'(j);
      end
    end
  end

  // Entries surviving a trim: expired ones form the tail of the sorted table
  always_comb begin
    live_cnt = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if ((CNT_W'(j) < cnt_q) && (tab_exp_q[j] > cmd_q.now)) begin
        live_cnt = live_cnt + CNT_W'(1);
      end
    end
  end

  // Insert slot: after every remaining entry with expiry at least the new one
  always_comb begin
    ins_pos = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if ((CNT_W'(j) < wc_q) && (tab_exp_q[j] >= cmd_q.expiry)) begin
        ins_pos = ins_pos + CNT_W'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    wc_d     = wc_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    emit_d   = emit_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        emit_d = '0;
        if (cmd_q.trim) begin
          cnt_d    = live_cnt;
          status_d = ST_TRIM;
          state_d  = S_EMIT;
        end else if (hit) begin
          idx_d    = hit_idx;
          wc_d     = cnt_q - CNT_W'(1);
          status_d = ST_REFRESH;
          state_d  = S_REMOVE;
        end else if (cmd_q.expiry == cmd_q.now) begin
          status_d = ST_EXPIRED;
          state_d  = S_EMIT;
        end else if (cnt_q < CNT_W'(ENTRIES)) begin
          wc_d     = cnt_q;
          status_d = ST_ADD;
          state_d  = S_INSERT;
        end else if (cmd_q.expiry >= tab_exp_q[ENTRIES-1]) begin
          // Oldest entry is the last one: dropping it needs no shift
          wc_d     = CNT_W'(ENTRIES - 1);
          status_d = ST_REPLACE;
          state_d  = S_INSERT;
        end else begin
          status_d = ST_FULL;
          state_d  = S_EMIT;
        end
      end
      S_REMOVE: begin
        state_d = S_INSERT;
      end
      S_INSERT: begin
        cnt_d   = wc_q + CNT_W'(1);
        emit_d  = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            emit_d = emit_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    wc_q     <= wc_d;
    status_q <= status_d;
    emit_q   <= emit_d;
    match_q  <= match_d;
    if (cmd_valid_i && cmd_ready_o) begin
      cmd_q <= cmd_i;
    end
  end

  // Table updates: close the gap at idx, then open one at the insert slot
  always_ff @(posedge clk_i) begin
    if (state_q == S_REMOVE) begin
      for (int j = 0; j < ENTRIES - 1; j++) begin
        if (IDX_W'(j) >= idx_q) begin
          tab_hi_q[j]  <= tab_hi_q[j+1];
          tab_lo_q[j]  <= tab_lo_q[j+1];
          tab_if_q[j]  <= tab_if_q[j+1];
          tab_exp_q[j] <= tab_exp_q[j+1];
        end
      end
    end else if (state_q == S_INSERT) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (CNT_W'(j) == ins_pos) begin
          tab_hi_q[j]  <= cmd_q.addr_high;
          tab_lo_q[j]  <= cmd_q.addr_low;
          tab_if_q[j]  <= cmd_q.iface;
          tab_exp_q[j] <= cmd_q.expiry;
        end else if ((j > 0) && (CNT_W'(j) > ins_pos)) begin
          tab_hi_q[j]  <= tab_hi_q[j-1];
          tab_lo_q[j]  <= tab_lo_q[j-1];
          tab_if_q[j]  <= tab_if_q[j-1];
          tab_exp_q[j] <= tab_exp_q[j-1];
        end
      end
    end
  end

  // Result payload; an empty table yields a single blank entry
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_stat_q <= status_q;
      o_cnt_q  <= cnt_q;
      o_last_q <= emit_last;
      if (cnt_q == '0) begin
        o_evalid_q <= 1'b0;
        o_hi_q     <= '0;
        o_lo_q     <= '0;
        o_if_q     <= '0;
        o_exp_q    <= '0;
        o_ll_q     <= 1'b0;
      end else begin
        o_evalid_q <= 1'b1;
        o_hi_q     <= tab_hi_q[emit_q];
        o_lo_q     <= tab_lo_q[emit_q];
        o_if_q     <= tab_if_q[emit_q];
        o_exp_q    <= tab_exp_q[emit_q];
        o_ll_q     <= is_link_local(tab_hi_q[emit_q]);
      end
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.entry_valid      = o_evalid_q;
  assign out_o.entry_addr_high  = o_hi_q;
  assign out_o.entry_addr_low   = o_lo_q;
  assign out_o.entry_iface      = o_if_q;
  assign out_o.entry_expiry     = o_exp_q;
  assign out_o.entry_link_local = o_ll_q;
  assign out_o.op_status        = o_stat_q;
  assign out_o.table_count      = TCOUNT_W'(o_cnt_q);
  assign out_o.is_last          = o_last_q;

endmodule

>>> rtl/expiring_server_table_top.sv
// ----------------------------------------------------------------------------
// expiring_server_table_top
// Table of server addresses with expiry times, sorted by falling expiry.
//
//   channel   dir   handshake      carries
//   in_i      in    valid/ready    func, address, iface index, expiry, now
//   out_o     out   valid/ready    one table entry per result, status, count
//
// The single sequencer in the table engine runs match, decide, remove and
// insert for a refresh; match, decide, insert to add or replace; match, decide
// when ignored and for a trim; then emit sends each entry (at least one).
// Reset empties the table at once; entry contents stay unwritten.
// The front register and a two-item queue take new items while the engine
// works or waits on a stalled output.
// ----------------------------------------------------------------------------
module expiring_server_table_top
  import esrv_pkg::*;
#(
  parameter int unsigned ENTRIES = ESRV_ENTRIES
) (
  input logic clk_i,
  input logic rst_ni,
  esrv_in_if.sink     in_i,
  esrv_out_if.source  out_o
);

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  esrv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  esrv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_cmd_o   (q_cmd)
  );

  esrv_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_o       (out_o)
  );

endmodule
